FILE: rtl/rahf_pkg.sv
// Shared types and constants for the RTP ack history feedback block.
package rahf_pkg;

    localparam int HIST_SIZE   = 256;
    localparam int HIST_AW     = $clog2(HIST_SIZE);
    localparam int MAX_REPORTS = 62;

    localparam int TIME_W = 32;
    localparam int SEQ_W  = 16;
    localparam int CE_W   = 2;
    localparam int NREP_W = 6;
    localparam int HIST_W = TIME_W + SEQ_W + CE_W;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 40;

    localparam logic [16:0] SEQ_WRAP_WIN = 17'd16384;
    localparam logic [16:0] SEQ_MOD      = 17'd65536;
    localparam logic [25:0] ATO_MAX      = 26'd8189;
    localparam logic [12:0] ATO_SAT      = 13'h1FFE;
    localparam logic [15:0] RX_BIT       = 16'h8000;

    localparam logic [5:0]  RC_RESET  = 6'd32;
    localparam logic [15:0] AD_RESET  = 16'd16;
    localparam logic [15:0] DC_RESET  = 16'd16;
    localparam logic [31:0] FBI_RESET = 32'd13107;

    localparam logic [1:0] CFG_REPORT_COUNT = 2'd0;
    localparam logic [1:0] CFG_ACK_DIFF     = 2'd1;
    localparam logic [1:0] CFG_DUE_COUNT    = 2'd2;
    localparam logic [1:0] CFG_FB_INTERVAL  = 2'd3;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_ELEM   = 2'd2,
        KIND_PAD    = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PKT,
        S_CHK,
        S_STAT,
        S_UPD,
        S_HDR,
        S_RD,
        S_EL,
        S_PAD
    } t_state;

    typedef struct packed {
        logic  load_in;
        logic  pkt_upd;
        logic  fb_upd;
        logic  rd_en;
        logic  k_inc;
        logic  ld_out;
        t_kind out_kind;
    } t_ctrl_cmd;

    typedef struct packed {
        logic fb_due;
        logic is_fb;
        logic out_free;
        logic last_elem;
        logic pad;
    } t_ctrl_sts;

endpackage

FILE: rtl/rtp_ack_history_feedback_top.sv
// Top level of the RTP ack history feedback generator.
//
// Input stream: s_tuser is the command (0 packet word, 1 feedback request).
// Each input word gives one or more output words; the last carries tlast.
// A packet word passes through capture, history write and state update,
// and status word load. A feedback request that is due passes through
// capture, command check, due check, report update and header load; then
// each report element is one registered read of the history RAM followed
// by the element word load, plus a padding word when their count is odd.
// A request that is not due gives one status word after its due check.
// One word is in flight at a time; s_tready is high only between words.
// The output word sits in a register; when m_tready is low it holds and
// the sequence waits, so no word is lost or repeated.
// Reset clears stream state, history valid bits and config to defaults;
// no clearing pass is needed. Config writes land at once via cfg_we.
module rtp_ack_history_feedback_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [31:0]                   i_cfg_data,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // time_now[31:0], seq_num[47:32], ce_bits[49:48], marker[50], zero fill
    input  logic [rahf_pkg::S_TDATA_W-1:0] i_s_tdata,
    // command[0]
    input  logic                          i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // begin_seq[15:0], num_reports[21:16], report_word[37:22],
    // ack_due[38], feedback_due[39]
    output logic [rahf_pkg::M_TDATA_W-1:0] o_m_tdata,
    // kind[1:0]
    output logic [1:0]                    o_m_tuser,
    output logic                          o_m_tlast
);
    import rahf_pkg::*;

    t_ctrl_cmd w_cmd;
    t_ctrl_sts w_sts;

    rahf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rahf_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts)
    );
endmodule

FILE: rtl/rahf_ram.sv
// Generic single-port-write, registered-read RAM.
module rahf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/rahf_ctrl.sv
// Controller state machine sequencing packet updates and feedback reports.
module rahf_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  rahf_pkg::t_ctrl_sts i_sts,
    output rahf_pkg::t_ctrl_cmd o_cmd
);
    import rahf_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_s_tready     = 1'b0;
        o_cmd          = '0;
        o_cmd.out_kind = KIND_STATUS;
        case (r_state)
            S_IDLE: begin
                o_s_tready   = 1'b1;
                o_cmd.load_in = i_s_tvalid;
                if (i_s_tvalid) begin
                    n_state = S_PKT;
                end
            end
            S_PKT: begin
                if (i_sts.is_fb) begin
                    n_state = S_CHK;
                end else begin
                    o_cmd.pkt_upd = 1'b1;
                    n_state       = S_STAT;
                end
            end
            S_CHK: begin
                n_state = i_sts.fb_due ? S_UPD : S_STAT;
            end
            S_STAT: begin
                if (i_sts.out_free) begin
                    o_cmd.ld_out   = 1'b1;
                    o_cmd.out_kind = KIND_STATUS;
                    n_state        = S_IDLE;
                end
            end
            S_UPD: begin
                o_cmd.fb_upd = 1'b1;
                n_state      = S_HDR;
            end
            S_HDR: begin
                if (i_sts.out_free) begin
                    o_cmd.ld_out   = 1'b1;
                    o_cmd.out_kind = KIND_HEADER;
                    n_state        = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_EL;
            end
            S_EL: begin
                if (i_sts.out_free) begin
                    o_cmd.ld_out   = 1'b1;
                    o_cmd.out_kind = KIND_ELEM;
                    o_cmd.k_inc    = 1'b1;
                    if (i_sts.last_elem) begin
                        n_state = i_sts.pad ? S_PAD : S_IDLE;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_PAD: begin
                if (i_sts.out_free) begin
                    o_cmd.ld_out   = 1'b1;
                    o_cmd.out_kind = KIND_PAD;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

FILE: rtl/rahf_dp.sv
// Datapath: config, stream state, history ring and output word register.
module rahf_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [31:0]                   i_cfg_data,
    input  logic [rahf_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic                          i_s_tuser,
    input  logic                          i_m_tready,
    output logic                          o_m_tvalid,
    output logic [rahf_pkg::M_TDATA_W-1:0] o_m_tdata,
    output logic [1:0]                    o_m_tuser,
    output logic                          o_m_tlast,
    input  rahf_pkg::t_ctrl_cmd           i_cmd,
    output rahf_pkg::t_ctrl_sts           o_sts
);
    import rahf_pkg::*;

    logic [5:0]  r_report_count;
    logic [15:0] r_ack_diff;
    logic [15:0] r_due_count;
    logic [31:0] r_fb_interval;

    logic        r_is_fb;
    logic [31:0] r_time;
    logic [15:0] r_seq;
    logic [1:0]  r_ce;
    logic        r_mark;

    logic        r_started;
    logic [15:0] r_highest;
    logic [15:0] r_hrs;
    logic        r_flush;
    logic [15:0] r_psr;
    logic [31:0] r_lrt;

    logic [NREP_W-1:0] r_n;
    logic [15:0]       r_sn_lo;
    logic [NREP_W-1:0] r_k;

    logic [HIST_SIZE-1:0] r_valid;
    logic                 r_vld_q;

    logic        r_out_valid;
    t_kind       r_out_kind;
    logic [15:0] r_out_bseq;
    logic [5:0]  r_out_nrep;
    logic [15:0] r_out_word;
    logic        r_out_ad;
    logic        r_out_fd;
    logic        r_out_last;

    logic [HIST_W-1:0] w_rdata;
    logic [31:0]       w_rtime;
    logic [15:0]       w_rseq;
    logic [1:0]        w_rce;

    logic [15:0] w_hcur;
    logic [16:0] w_sext;
    logic [16:0] w_hext;
    logic [15:0] w_adv;
    logic [5:0]  w_nclamp;
    logic [15:0] w_sn_lo;
    logic [15:0] w_hrs_new;
    logic        w_ack;
    logic        w_fb;
    logic [31:0] w_age;
    logic [15:0] w_sn;
    logic [31:0] w_diff;
    logic [12:0] w_ato;
    logic [15:0] w_word;
    logic        w_last_elem;
    logic        w_out_last;
    logic [HIST_AW-1:0] w_raddr;

    assign w_rtime = w_rdata[HIST_W-1 -: TIME_W];
    assign w_rseq  = w_rdata[CE_W +: SEQ_W];
    assign w_rce   = w_rdata[CE_W-1:0];
    assign w_raddr = w_sn[HIST_AW-1:0];

    rahf_ram #(
        .WIDTH (HIST_W),
        .DEPTH (HIST_SIZE)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (i_cmd.pkt_upd),
        .i_waddr (r_seq[HIST_AW-1:0]),
        .i_wdata ({r_time, r_seq, r_ce}),
        .i_re    (i_cmd.rd_en),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_hcur = r_started ? r_highest : (r_seq - 16'd1);
        w_sext = {1'b0, r_seq};
        w_hext = {1'b0, w_hcur};
        if (r_seq < w_hcur && {1'b0, w_hcur - r_seq} > SEQ_WRAP_WIN) begin
            w_sext = w_sext + SEQ_MOD;
        end
        if (w_hcur < r_seq && {1'b0, r_seq - w_hcur} > SEQ_WRAP_WIN) begin
            w_hext = w_hext + SEQ_MOD;
        end
    end

    always_comb begin
        w_adv = r_highest - r_hrs;
        if (r_report_count == 6'd0) begin
            w_nclamp = 6'd1;
        end else if (r_report_count > 6'(MAX_REPORTS)) begin
            w_nclamp = 6'(MAX_REPORTS);
        end else begin
            w_nclamp = r_report_count;
        end
        if (w_adv > {10'd0, w_nclamp}) begin
            w_sn_lo   = r_hrs + 16'd1;
            w_hrs_new = w_sn_lo + {10'd0, w_nclamp} - 16'd1;
        end else begin
            w_hrs_new = r_highest;
            w_sn_lo   = r_highest - {10'd0, w_nclamp} + 16'd1;
        end
    end

    assign w_age = r_time - r_lrt;
    assign w_ack = (r_ack_diff <= 16'd1) || (w_adv >= r_ack_diff) || r_flush;
    assign w_fb  = (r_psr >= r_due_count) || r_flush || (w_age > r_fb_interval) ||
                   (r_is_fb && r_mark && (r_psr != 16'd0));

    always_comb begin
        w_sn   = r_sn_lo + {10'd0, r_k};
        w_diff = r_time - w_rtime;
        w_ato  = (w_diff[31:6] > ATO_MAX) ? ATO_SAT : w_diff[18:6];
        if (r_vld_q && (w_rseq == w_sn) && (w_rtime != 32'd0)) begin
            w_word = RX_BIT | {1'b0, w_rce, w_ato};
        end else begin
            w_word = 16'd0;
        end
    end

    assign w_last_elem = ((r_k + 6'd1) == r_n);

    always_comb begin
        case (i_cmd.out_kind)
            KIND_STATUS: w_out_last = 1'b1;
            KIND_HEADER: w_out_last = 1'b0;
            KIND_ELEM:   w_out_last = !r_n[0] && w_last_elem;
            KIND_PAD:    w_out_last = 1'b1;
            default:     w_out_last = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_report_count <= RC_RESET;
            r_ack_diff     <= AD_RESET;
            r_due_count    <= DC_RESET;
            r_fb_interval  <= FBI_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_REPORT_COUNT: r_report_count <= i_cfg_data[5:0];
                CFG_ACK_DIFF:     r_ack_diff     <= i_cfg_data[15:0];
                CFG_DUE_COUNT:    r_due_count    <= i_cfg_data[15:0];
                CFG_FB_INTERVAL:  r_fb_interval  <= i_cfg_data;
                default:          r_fb_interval  <= r_fb_interval;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_is_fb <= i_s_tuser;
            r_time  <= i_s_tdata[31:0];
            r_seq   <= i_s_tdata[47:32];
            r_ce    <= i_s_tdata[49:48];
            r_mark  <= i_s_tdata[50];
        end
        if (i_cmd.fb_upd) begin
            r_n     <= w_nclamp;
            r_sn_lo <= w_sn_lo;
        end
        if (i_cmd.rd_en) begin
            r_vld_q <= r_valid[w_raddr];
        end
        if (i_cmd.ld_out) begin
            r_out_kind <= i_cmd.out_kind;
            r_out_bseq <= (i_cmd.out_kind == KIND_HEADER) ? r_sn_lo : 16'd0;
            r_out_nrep <= (i_cmd.out_kind == KIND_HEADER) ? r_n : 6'd0;
            r_out_word <= (i_cmd.out_kind == KIND_ELEM) ? w_word : 16'd0;
            r_out_ad   <= w_ack;
            r_out_fd   <= w_fb;
            r_out_last <= w_out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started   <= 1'b0;
            r_highest   <= '0;
            r_hrs       <= '0;
            r_flush     <= 1'b0;
            r_psr       <= '0;
            r_lrt       <= '0;
            r_valid     <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.pkt_upd) begin
                if (r_psr != 16'hFFFF) begin
                    r_psr <= r_psr + 16'd1;
                end
                if (r_mark) begin
                    r_flush <= 1'b1;
                end
                r_started                   <= 1'b1;
                r_valid[r_seq[HIST_AW-1:0]] <= 1'b1;
                r_highest <= (w_sext >= w_hext) ? r_seq : w_hcur;
            end
            if (i_cmd.fb_upd) begin
                r_hrs   <= w_hrs_new;
                r_flush <= (w_hrs_new != r_highest);
                r_lrt   <= r_time;
                r_psr   <= '0;
                r_k     <= '0;
            end else if (i_cmd.k_inc) begin
                r_k <= r_k + 6'd1;
            end
            if (i_cmd.ld_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.fb_due    = w_fb;
    assign o_sts.is_fb     = r_is_fb;
    assign o_sts.out_free  = !r_out_valid || i_m_tready;
    assign o_sts.last_elem = w_last_elem;
    assign o_sts.pad       = r_n[0];

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {r_out_fd, r_out_ad, r_out_word, r_out_nrep, r_out_bseq};

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ld_out |-> (!r_out_valid || i_m_tready))
        else $error("output word overwritten before taken");
    a_read_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_en |-> (r_k < r_n))
        else $error("history read beyond report count");
    a_fb_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fb_upd |=> (r_psr == 16'd0 && r_lrt == $past(r_time)))
        else $error("report did not clear packet count");
    a_pkt_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pkt_upd |=> r_started)
        else $error("packet did not start stream");
`endif
endmodule
